// ----- rtl/core/cc8u_pkg.sv -----
package cc8u_pkg;

  localparam int unsigned NumWords   = 16;
  localparam int unsigned WordW      = 32;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned CntW       = 5;
  localparam int unsigned FloatW     = 30;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [WordW-1:0] Sigma0 = 32'h6170_7865;
  localparam logic [WordW-1:0] Sigma1 = 32'h3320_646e;
  localparam logic [WordW-1:0] Sigma2 = 32'h7962_2d32;
  localparam logic [WordW-1:0] Sigma3 = 32'h6b20_6574;

  // exponent of 2^-23 scaling, plus the bit position of the leading one
  localparam logic [6:0] ExpBase = 7'd104;

  typedef logic [NumWords-1:0][WordW-1:0] cc8u_block_t;

  typedef struct packed {
    cc8u_block_t       words;
    logic [63:0]       ctr;
    logic [CntW-1:0]   cnt;
  } cc8u_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cc8u_queue_stat_t;

  // initial state word k for a given seed and counter
  function automatic logic [WordW-1:0] init_word(logic [IdxW-1:0] k, logic [63:0] seed,
                                                 logic [63:0] ctr);
    logic [WordW-1:0] w;
    case (k) inside
      4'd0:     w = Sigma0;
      4'd1:     w = Sigma1;
      4'd2:     w = Sigma2;
      4'd3:     w = Sigma3;
      [4'd4:4'd11]: w = k[0] ? seed[63:32] : seed[31:0];
      4'd12:    w = ctr[31:0];
      4'd13:    w = ctr[63:32];
      default:  w = '0;
    endcase
    return w;
  endfunction

  function automatic cc8u_block_t init_block(logic [63:0] seed, logic [63:0] ctr);
    cc8u_block_t b;
    for (int k = 0; k < NumWords; k++) begin
      b[k] = init_word(IdxW'(k), seed, ctr);
    end
    return b;
  endfunction

  // one half of a quarter round on all four lanes; diag picks the diagonal round,
  // second picks the 8/7 rotation half
  function automatic cc8u_block_t half_round(cc8u_block_t s, logic diag, logic second);
    cc8u_block_t      r;
    logic [1:0]       jj;
    logic [IdxW-1:0]  ia, ib, ic, id;
    logic [WordW-1:0] a, b, c, d;
    r = s;
    for (int j = 0; j < 4; j++) begin
      jj = 2'(j);
      ia = {2'b00, jj};
      ib = {2'b01, 2'(jj + {1'b0, diag})};
      ic = {2'b10, 2'(jj + {diag, 1'b0})};
      id = {2'b11, 2'(jj + {diag, diag})};
      a  = s[ia];
      b  = s[ib];
      c  = s[ic];
      d  = s[id];
      a  = a + b;
      d  = d ^ a;
      d  = second ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
      c  = c + d;
      b  = b ^ c;
      b  = second ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
      r[ia] = a;
      r[ib] = b;
      r[ic] = c;
      r[id] = d;
    end
    return r;
  endfunction

  // exact single-precision bits of (w >> 9) * 2^-23 without the sign and exponent MSB, both zero
  function automatic logic [FloatW-1:0] unit_float(logic [WordW-1:0] w);
    logic [22:0] m;
    logic [4:0]  t;
    logic [22:0] mant;
    logic [6:0]  e;
    m = w[31:9];
    t = '0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) t = 5'(i);
    end
    mant = m << (5'd23 - t);
    e    = ExpBase + {2'b00, t};
    return (m == '0) ? '0 : {e, mant};
  endfunction

endpackage

// ----- rtl/core/cc8u_core.sv -----
module cc8u_core #(
  parameter int unsigned DOUBLE_ROUNDS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [63:0]                   block_counter_i,
  input  logic [cc8u_pkg::CntW-1:0]     word_count_i,
  input  logic [63:0]                   seed_i,
  input  cc8u_pkg::cc8u_queue_stat_t    q_stat_i,
  output logic                          busy_o,
  output logic                          push_o,
  output cc8u_pkg::cc8u_entry_t         entry_o
);

  localparam int unsigned Steps = 4 * DOUBLE_ROUNDS;
  localparam int unsigned StepW = $clog2(Steps);
  localparam logic [StepW-1:0] LastStep = StepW'(Steps - 1);

  logic                      run_q, run_d;
  logic                      hold_q, hold_d;
  logic [StepW-1:0]          step_q, step_d;
  cc8u_pkg::cc8u_block_t     st_q, st_d;
  logic [63:0]               ctr_q, ctr_d;
  logic [cc8u_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [cc8u_pkg::CntW-1:0] cnt_sat;
  logic                      accept;

  // counts above a full block clamp to a full block
  assign cnt_sat = word_count_i[4] ? 5'd16 : word_count_i;

  assign push_o = hold_q;
  assign busy_o = run_q | (hold_q & q_stat_i.full);
  assign accept = start_i & ~busy_o;

  assign entry_o.words = st_q;
  assign entry_o.ctr   = ctr_q;
  assign entry_o.cnt   = cnt_q;

  always_comb begin
    run_d  = run_q;
    hold_d = hold_q;
    step_d = step_q;
    st_d   = st_q;
    ctr_d  = ctr_q;
    cnt_d  = cnt_q;
    if (hold_q && !q_stat_i.full) begin
      hold_d = 1'b0;
    end
    if (run_q) begin
      // step bit 0 selects the rotation half, bit 1 column versus diagonal
      st_d   = cc8u_pkg::half_round(st_q, step_q[1], step_q[0]);
      step_d = step_q + 1'b1;
      if (step_q == LastStep) begin
        run_d  = 1'b0;
        hold_d = 1'b1;
        step_d = '0;
      end
    end else if (accept && cnt_sat != '0) begin
      run_d  = 1'b1;
      step_d = '0;
      st_d   = cc8u_pkg::init_block(seed_i, block_counter_i);
      ctr_d  = block_counter_i;
      cnt_d  = cnt_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      hold_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      hold_q <= hold_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    ctr_q <= ctr_d;
    cnt_q <= cnt_d;
  end

endmodule

// ----- rtl/core/cc8u_queue.sv -----
module cc8u_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  cc8u_pkg::cc8u_entry_t      entry_i,
  input  logic                       pop_i,
  output cc8u_pkg::cc8u_queue_stat_t stat_o,
  output cc8u_pkg::cc8u_entry_t      head_o
);

  localparam int unsigned CountW = $clog2(cc8u_pkg::QueueDepth + 1);

  cc8u_pkg::cc8u_entry_t               mem_q [cc8u_pkg::QueueDepth];
  logic [cc8u_pkg::QueuePtrW-1:0]      wptr_q, wptr_d;
  logic [cc8u_pkg::QueuePtrW-1:0]      rptr_q, rptr_d;
  logic [CountW-1:0]                   count_q, count_d;
  logic                                do_push, do_pop;

  assign stat_o.full  = (count_q == CountW'(cc8u_pkg::QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem_q[rptr_q];

  assign do_push = push_i & ~stat_o.full;
  assign do_pop  = pop_i & ~stat_o.empty;

  always_comb begin
    wptr_d  = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = do_pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

// ----- rtl/core/cc8u_emit.sv -----
module cc8u_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cc8u_pkg::cc8u_queue_stat_t    q_stat_i,
  input  cc8u_pkg::cc8u_entry_t         head_i,
  input  logic [63:0]                   seed_i,
  output logic                          pop_o,
  output logic                          valid_o,
  output logic [cc8u_pkg::IdxW-1:0]     word_index_o,
  output logic [cc8u_pkg::WordW-1:0]    raw_word_o,
  output logic [cc8u_pkg::FloatW-1:0]   unit_float_bits_o,
  output logic                          last_o
);

  logic                       act_q, act_d;
  logic [cc8u_pkg::IdxW-1:0]  k_q, k_d;
  logic [cc8u_pkg::CntW-1:0]  cnt_q, cnt_d;
  cc8u_pkg::cc8u_block_t      words_q, words_d;
  logic [63:0]                ctr_q, ctr_d;
  logic                       last_word;

  // stage 1: feed-forward sum
  logic                       s1_vld_q;
  logic [cc8u_pkg::IdxW-1:0]  s1_idx_q;
  logic [cc8u_pkg::WordW-1:0] s1_word_q, s1_word_d;
  logic                       s1_last_q;

  // stage 2: result registers
  logic                        out_vld_q;
  logic [cc8u_pkg::IdxW-1:0]   out_idx_q;
  logic [cc8u_pkg::WordW-1:0]  out_raw_q;
  logic [cc8u_pkg::FloatW-1:0] out_flt_q;
  logic                        out_last_q;

  assign last_word = ({1'b0, k_q} + 5'd1) == cnt_q;
  assign pop_o     = ~q_stat_i.empty & (~act_q | last_word);
  assign s1_word_d = words_q[k_q] + cc8u_pkg::init_word(k_q, seed_i, ctr_q);

  always_comb begin
    act_d   = act_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    words_d = words_q;
    ctr_d   = ctr_q;
    if (pop_o) begin
      act_d   = 1'b1;
      k_d     = '0;
      cnt_d   = head_i.cnt;
      words_d = head_i.words;
      ctr_d   = head_i.ctr;
    end else if (act_q && last_word) begin
      act_d = 1'b0;
    end else if (act_q) begin
      k_d = k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      k_q       <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      act_q     <= act_d;
      k_q       <= k_d;
      s1_vld_q  <= act_q;
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    words_q    <= words_d;
    ctr_q      <= ctr_d;
    s1_idx_q   <= k_q;
    s1_word_q  <= s1_word_d;
    s1_last_q  <= last_word;
    out_idx_q  <= s1_idx_q;
    out_raw_q  <= s1_word_q;
    out_flt_q  <= cc8u_pkg::unit_float(s1_word_q);
    out_last_q <= s1_last_q;
  end

  assign valid_o           = out_vld_q;
  assign word_index_o      = out_idx_q;
  assign raw_word_o        = out_raw_q;
  assign unit_float_bits_o = out_flt_q;
  assign last_o            = out_last_q;

endmodule

// ----- rtl/core/chacha8_block_to_unit_float_unit.sv -----
// ChaCha keystream block to unit-interval floats. A block is accepted when start_i is high
// and busy_o is low; the round core then applies one half quarter round on all four lanes per
// cycle over all DOUBLE_ROUNDS double rounds and hands the block to a two-entry queue; busy_o
// is high while rounds run or a finished block waits on a full queue, so a new block can be
// taken while the last is handed over. The output side drains the queue at one word per cycle;
// each word passes the loaded block register, feed-forward sum stage and result registers.
// Results are strobed by valid_o for a single cycle and cannot be held off. A word count of
// zero is accepted and produces nothing; counts above 16 emit 16 words. The seed register
// sits at address 0 of the APB port and must only be written while no block is in flight.
module chacha8_block_to_unit_float_unit #(
  parameter int unsigned DOUBLE_ROUNDS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [63:0]                   block_counter_i,
  input  logic [cc8u_pkg::CntW-1:0]     word_count_i,
  output logic                          valid_o,
  output logic [cc8u_pkg::IdxW-1:0]     word_index_o,
  output logic [cc8u_pkg::WordW-1:0]    raw_word_o,
  output logic [cc8u_pkg::FloatW-1:0]   unit_float_bits_o,
  output logic                          last_o
);

  logic [63:0]                seed_q, seed_d;
  logic                       seed_sel;
  logic                       push;
  logic                       pop;
  cc8u_pkg::cc8u_entry_t      push_entry;
  cc8u_pkg::cc8u_entry_t      head_entry;
  cc8u_pkg::cc8u_queue_stat_t q_stat;

  assign pready   = 1'b1;
  assign seed_sel = (paddr[3] == 1'b0);
  assign prdata   = seed_sel ? seed_q : '0;
  assign seed_d   = (psel && penable && pwrite && pready && seed_sel) ? pwdata : seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else begin
      seed_q <= seed_d;
    end
  end

  cc8u_core #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .block_counter_i (block_counter_i),
    .word_count_i    (word_count_i),
    .seed_i          (seed_q),
    .q_stat_i        (q_stat),
    .busy_o          (busy_o),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  cc8u_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .stat_o  (q_stat),
    .head_o  (head_entry)
  );

  cc8u_emit u_emit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_stat_i          (q_stat),
    .head_i            (head_entry),
    .seed_i            (seed_q),
    .pop_o             (pop),
    .valid_o           (valid_o),
    .word_index_o      (word_index_o),
    .raw_word_o        (raw_word_o),
    .unit_float_bits_o (unit_float_bits_o),
    .last_o            (last_o)
  );

endmodule
